// ===== design/tts_pkg.sv =====
`timescale 1ns / 1ps

package tts_pkg;

    // Operation codes carried in the request
    localparam logic [2:0] MODE_ADD_ONE    = 3'd0;
    localparam logic [2:0] MODE_ADD_REP    = 3'd1;
    localparam logic [2:0] MODE_CANCEL_ONE = 3'd2;
    localparam logic [2:0] MODE_CANCEL_REP = 3'd3;
    localparam logic [2:0] MODE_CLEAR_ONE  = 3'd4;
    localparam logic [2:0] MODE_CLEAR_REP  = 3'd5;
    localparam logic [2:0] MODE_CLEAR_ALL  = 3'd6;
    localparam logic [2:0] MODE_HANDLE     = 3'd7;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOMATCH = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int ACTION_W = 8;

    typedef struct packed {
        logic [2:0]          mode;
        logic [PERIOD_W-1:0] period;
        logic [ACTION_W-1:0] action_id;
        logic [TIME_W-1:0]   now;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic                fired;
        logic [ACTION_W-1:0] fired_action;
        logic                next_valid;
        logic [TIME_W-1:0]   until_next;
    } t_rsp;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   expiry;
        logic [ACTION_W-1:0] action;
        logic                rpt;
    } t_entry;

    // Verdict on one table entry during a scan
    typedef struct packed {
        logic              keep;   // entry stays in the table
        logic              fire;   // entry served by handle
        logic              early;  // handle, nothing fired yet, not expired: left is meaningful
        logic [TIME_W-1:0] left;
        t_entry            entry;  // entry as written back
    } t_eval;

    // now + period, saturated to the time width
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [PERIOD_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W-PERIOD_W+1){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// ===== design/timer_table_scheduler.sv =====
`timescale 1ns / 1ps
// Flow: add and clear-all go straight to the finish state once the request is taken;
//   cancel, clear and handle first scan the table, reading each live entry in turn;
//   the result then waits in the finish state while i_out_ready holds the output full.
// Throughput: one request at a time; the scan reads one entry a cycle through the
//   entry memory, with its separate read and write ports, and one shared decision unit.
// Reset (i_rst_n low, synchronous): table emptied (count zero), no result pending.

module timer_table_scheduler #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tts_pkg::t_req  i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tts_pkg::t_rsp  o_out_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;

    // live entry count; entries at and above it are never read
    logic [CW-1:0] r_count, n_count;

    // scan pointers: reads run ahead, kept entries are packed down at the write pointer,
    // so removal closes gaps in one pass with order preserved
    logic [CW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_wr_ptr, n_wr_ptr;
    logic          r_rd_vld, n_rd_vld;

    tts_pkg::t_req r_req, n_req;

    // handle / remove bookkeeping across the scan
    logic                       r_fired, n_fired;
    logic [tts_pkg::ACTION_W-1:0] r_fact, n_fact;
    logic                       r_nv, n_nv;
    logic [tts_pkg::TIME_W-1:0] r_min, n_min;
    logic                       r_found, n_found;

    // finished result waiting for the output register, and the output register
    tts_pkg::t_rsp r_rsp, n_rsp;
    tts_pkg::t_rsp r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // entry memory: one write and one registered read a cycle
    tts_pkg::t_entry r_mem [DEPTH];
    tts_pkg::t_entry r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    tts_pkg::t_entry mem_wd;
    logic [AW-1:0]   mem_ra;

    tts_pkg::t_eval ev;
    logic           issue;

    tts_eval u_eval (
        .i_entry (r_rd_data),
        .i_req   (r_req),
        .i_fired (r_fired),
        .o_res   (ev)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_rd_vld    = 1'b0;
        n_req       = r_req;
        n_fired     = r_fired;
        n_fact      = r_fact;
        n_nv        = r_nv;
        n_min       = r_min;
        n_found     = r_found;
        n_rsp       = r_rsp;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        mem_we = 1'b0;
        mem_wa = r_wr_ptr[AW-1:0];
        mem_wd = ev.entry;
        mem_ra = r_rd_ptr[AW-1:0];
        issue  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_req;
                    n_rsp = '0;
                    unique case (i_in_req.mode) inside
                        tts_pkg::MODE_ADD_ONE, tts_pkg::MODE_ADD_REP: begin
                            if (r_count < CW'(DEPTH)) begin
                                mem_we        = 1'b1;
                                mem_wa        = r_count[AW-1:0];
                                mem_wd.period = i_in_req.period;
                                mem_wd.expiry = tts_pkg::sat_add(i_in_req.now,
                                                                 i_in_req.period);
                                mem_wd.action = i_in_req.action_id;
                                mem_wd.rpt    = (i_in_req.mode == tts_pkg::MODE_ADD_REP);
                                n_count       = r_count + CW'(1);
                            end else begin
                                n_rsp.status = tts_pkg::STATUS_FULL;
                            end
                            n_state = ST_FINISH;
                        end
                        tts_pkg::MODE_CLEAR_ALL: begin
                            n_count = '0;
                            n_state = ST_FINISH;
                        end
                        default: begin
                            n_rd_ptr = '0;
                            n_wr_ptr = '0;
                            n_fired  = 1'b0;
                            n_fact   = '0;
                            n_nv     = 1'b0;
                            n_min    = '0;
                            n_found  = 1'b0;
                            n_state  = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // fetch the next entry
                issue    = (r_rd_ptr < r_count);
                n_rd_vld = issue;
                if (issue) begin
                    n_rd_ptr = r_rd_ptr + CW'(1);
                end
                // judge the entry fetched last cycle
                if (r_rd_vld) begin
                    if (ev.keep) begin
                        mem_we   = 1'b1;
                        n_wr_ptr = r_wr_ptr + CW'(1);
                    end else begin
                        n_found = 1'b1;
                    end
                    if (ev.fire) begin
                        n_fired = 1'b1;
                        n_fact  = ev.entry.action;
                    end
                    if (ev.early && (!r_nv || (ev.left < r_min))) begin
                        n_nv  = 1'b1;
                        n_min = ev.left;
                    end
                end
                if (!issue && !r_rd_vld) begin
                    n_count = r_wr_ptr;
                    n_rsp   = '0;
                    if (r_req.mode == tts_pkg::MODE_HANDLE) begin
                        n_rsp.fired        = r_fired;
                        n_rsp.fired_action = r_fact;
                        n_rsp.next_valid   = r_nv && !r_fired;
                        n_rsp.until_next   = (r_nv && !r_fired) ? r_min : '0;
                    end else if (!r_found) begin
                        n_rsp.status = tts_pkg::STATUS_NOMATCH;
                    end
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_rsp;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fired     <= 1'b0;
            r_nv        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_fired     <= n_fired;
            r_nv        <= n_nv;
            r_found     <= n_found;
        end
        r_req  <= n_req;
        r_fact <= n_fact;
        r_min  <= n_min;
        r_rsp  <= n_rsp;
        r_out  <= n_out;
    end

endmodule

// ===== design/tts_eval.sv =====
`timescale 1ns / 1ps

// Per-entry decision unit, shared by every step of a scan.
module tts_eval (
    input  tts_pkg::t_entry i_entry,
    input  tts_pkg::t_req   i_req,
    input  logic            i_fired,
    output tts_pkg::t_eval  o_res
);

    logic [tts_pkg::TIME_W:0] diff;
    logic                     expired;
    logic                     kind_ok;
    logic                     key_ok;
    logic                     remove;

    always_comb begin
        diff    = {1'b0, i_entry.expiry} - {1'b0, i_req.now};
        expired = diff[tts_pkg::TIME_W] || (diff[tts_pkg::TIME_W-1:0] == '0);
        key_ok  = (i_entry.period == i_req.period) && (i_entry.action == i_req.action_id);

        case (i_req.mode) inside
            tts_pkg::MODE_CANCEL_ONE, tts_pkg::MODE_CLEAR_ONE: kind_ok = !i_entry.rpt;
            tts_pkg::MODE_CANCEL_REP, tts_pkg::MODE_CLEAR_REP: kind_ok = i_entry.rpt;
            default:                                           kind_ok = 1'b0;
        endcase

        // cancel matches the key too; clear only the kind
        remove = kind_ok && (key_ok || (i_req.mode == tts_pkg::MODE_CLEAR_ONE)
                                    || (i_req.mode == tts_pkg::MODE_CLEAR_REP));

        o_res       = '0;
        o_res.entry = i_entry;
        o_res.left  = diff[tts_pkg::TIME_W-1:0];

        if (i_req.mode == tts_pkg::MODE_HANDLE) begin
            if (!i_fired && expired) begin
                o_res.fire         = 1'b1;
                o_res.keep         = i_entry.rpt;
                o_res.entry.expiry = tts_pkg::sat_add(i_req.now, i_entry.period);
            end else begin
                o_res.keep  = 1'b1;
                o_res.early = !i_fired;
            end
        end else begin
            o_res.keep = !remove;
        end
    end

endmodule
